[rtl/core/pcpd_pkg.sv]
`timescale 1ns / 1ps
// Package for the patch column post decoder: field widths, register indexes,
// result kinds and the word passed from the parser to the address stage.
// No dependencies.
package pcpd_pkg;

    localparam int DATA_W      = 8;
    localparam int COORD_W     = 16;
    localparam int ROW_W       = 18;
    localparam int ADDR_W      = 24;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam int MAX_IMAGE_SIDE_DEF = 4096;

    localparam logic [DATA_W-1:0] END_MARK = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT  = 2'd3;

    localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH  = 13'd320;
    localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT = 13'd200;
    localparam logic [DATA_W-1:0] RST_TRANSPARENT  = 8'd247;
    localparam logic [DATA_W-1:0] RST_REPLACEMENT  = 8'd0;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_COL_END = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [ROW_W-1:0]    row;
        logic [COORD_W-1:0]  x;
        logic [DATA_W-1:0]   value;
    } t_pix_req;

endpackage

[rtl/core/pcpd_parser.sv]
`timescale 1ns / 1ps
// Post parser: walks the column byte stream, keeps the column origin and row,
// and registers at most one pixel or column-end request per word. Uses pcpd_pkg.
module pcpd_parser #(
    parameter int SIDE_W = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_advance,
    input  logic [pcpd_pkg::DATA_W-1:0]   i_data_byte,
    input  logic                          i_column_start,
    input  logic [pcpd_pkg::COORD_W-1:0]  i_column_x,
    input  logic [pcpd_pkg::COORD_W-1:0]  i_column_y,
    input  logic [SIDE_W-1:0]             i_width,
    input  logic [SIDE_W-1:0]             i_height,
    input  logic [pcpd_pkg::DATA_W-1:0]   i_transparent,
    input  logic [pcpd_pkg::DATA_W-1:0]   i_replacement,
    output logic                          o_valid,
    output pcpd_pkg::t_pix_req            o_req
);
    import pcpd_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TOP  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_PAD1 = 3'd3;
    localparam logic [2:0] PH_PIX  = 3'd4;
    localparam logic [2:0] PH_PAD2 = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    logic [2:0]          r_phase,  n_phase;
    logic [DATA_W-1:0]   r_left,   n_left;
    logic [ROW_W-1:0]    r_row,    n_row;
    logic [COORD_W-1:0]  r_ox,     n_ox;
    logic [COORD_W-1:0]  r_oy,     n_oy;
    logic                r_valid,  n_valid;
    t_pix_req            r_req,    n_req;

    logic [2:0]          eff_phase;
    logic [DATA_W-1:0]   eff_left;
    logic [DATA_W-1:0]   left_dec;
    logic                x_in;
    logic                row_in;
    logic                emit;

    always_comb begin
        eff_phase = i_column_start ? PH_TOP : r_phase;
        eff_left  = i_column_start ? '0 : r_left;
        left_dec  = eff_left - DATA_W'(1);
        x_in      = !r_ox[COORD_W-1] && (17'(r_ox) < 17'(i_width));
        row_in    = !r_row[ROW_W-1] && (r_row < ROW_W'(i_height));

        n_phase = r_phase;
        n_left  = r_left;
        n_row   = r_row;
        n_ox    = r_ox;
        n_oy    = r_oy;
        emit    = 1'b0;
        n_req.kind  = KIND_PIXEL;
        n_req.row   = r_row;
        n_req.x     = r_ox;
        n_req.value = (i_data_byte == i_transparent) ? i_replacement : i_data_byte;

        if (i_accept) begin
            if (i_column_start) begin
                n_ox   = i_column_x;
                n_oy   = i_column_y;
                n_left = '0;
                n_phase = PH_TOP;
            end
            unique case (eff_phase)
                PH_TOP: begin
                    if (i_data_byte == END_MARK) begin
                        n_phase     = PH_DONE;
                        emit        = 1'b1;
                        n_req.kind  = KIND_COL_END;
                        n_req.value = '0;
                    end else begin
                        n_row   = {{(ROW_W-COORD_W){n_oy[COORD_W-1]}}, n_oy}
                                  + ROW_W'(i_data_byte);
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_left  = i_data_byte;
                    n_phase = PH_PAD1;
                end
                PH_PAD1: begin
                    n_phase = (eff_left != '0) ? PH_PIX : PH_PAD2;
                end
                PH_PIX: begin
                    n_row  = r_row + ROW_W'(1);
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_PAD2;
                    end
                    emit = x_in && row_in;
                end
                PH_PAD2: begin
                    n_phase = PH_TOP;
                end
                default: begin
                end
            endcase
        end

        n_valid = i_advance ? emit : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
            r_row   <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_row   <= n_row;
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

[rtl/core/pcpd_addr.sv]
`timescale 1ns / 1ps
// Address stage: forms row * width + x for pixel requests and holds the
// result word in the output register. Uses pcpd_pkg.
module pcpd_addr #(
    parameter int SIDE_W = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  pcpd_pkg::t_pix_req            i_req,
    input  logic [SIDE_W-1:0]             i_width,
    input  logic                          i_out_ready,
    output logic                          o_advance,
    output logic                          o_valid,
    output logic                          o_kind,
    output logic [pcpd_pkg::ADDR_W-1:0]   o_addr,
    output logic [pcpd_pkg::DATA_W-1:0]   o_value
);
    import pcpd_pkg::*;

    localparam int PROD_W = 2 * SIDE_W;
    localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

    logic                r_valid;
    logic                r_kind;
    logic [ADDR_W-1:0]   r_addr,  n_addr;
    logic [DATA_W-1:0]   r_value;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    sum;

    always_comb begin
        prod = i_req.row[SIDE_W-1:0] * i_width;
        sum  = SUM_W'(prod) + SUM_W'(i_req.x);
        n_addr = (i_req.kind == KIND_COL_END) ? '0 : sum[ADDR_W-1:0];
    end

    assign o_advance = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_kind  <= i_req.kind;
            r_addr  <= n_addr;
            r_value <= i_req.value;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_addr  = r_addr;
    assign o_value = r_value;

endmodule

[rtl/core/patch_column_post_decoder.sv]
`timescale 1ns / 1ps
// Patch column post decoder, top level: configuration registers, post parser
// and address stage. Uses pcpd_pkg, pcpd_parser and pcpd_addr.
// Results pass the parser request register, then the address stage register.
// Throughput: one input word per cycle unless the output stalls, set by the
// parser and the multiply-add of the address stage, each between registers.
// Reset (synchronous, active low) idles the parser and restores the registers.
module patch_column_post_decoder #(
    parameter int MAX_IMAGE_SIDE = pcpd_pkg::MAX_IMAGE_SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcpd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcpd_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // data_byte [7:0], column_x [23:8], column_y [39:24]
    input  logic [pcpd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // column_start [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_address [23:0], pixel_value [31:24]
    output logic [pcpd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // result_kind [0]
    output logic                              m_axis_tuser
);
    import pcpd_pkg::*;

    localparam int SIDE_W = $clog2(MAX_IMAGE_SIDE + 1);

    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   r_height;
    logic [DATA_W-1:0]  r_transparent;
    logic [DATA_W-1:0]  r_replacement;

    logic [SIDE_W-1:0]  width_c;
    logic [SIDE_W-1:0]  height_c;
    logic               advance;
    logic               accept;
    logic               out_ready_path;
    logic               req_valid;
    t_pix_req           req;
    logic               out_kind;
    logic [ADDR_W-1:0]  out_addr;
    logic [DATA_W-1:0]  out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= RST_IMAGE_WIDTH;
            r_height      <= RST_IMAGE_HEIGHT;
            r_transparent <= RST_TRANSPARENT;
            r_replacement <= RST_REPLACEMENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width       <= i_cfg_wdata;
                REG_IMAGE_HEIGHT: r_height      <= i_cfg_wdata;
                REG_TRANSPARENT:  r_transparent <= i_cfg_wdata[DATA_W-1:0];
                REG_REPLACEMENT:  r_replacement <= i_cfg_wdata[DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        width_c  = (32'(r_width) > 32'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE)
                                                        : SIDE_W'(r_width);
        height_c = (32'(r_height) > 32'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE)
                                                         : SIDE_W'(r_height);
    end

    assign advance       = !req_valid || out_ready_path;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    pcpd_parser #(
        .SIDE_W (SIDE_W)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_advance      (advance),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_column_start (s_axis_tuser),
        .i_column_x     (s_axis_tdata[23:8]),
        .i_column_y     (s_axis_tdata[39:24]),
        .i_width        (width_c),
        .i_height       (height_c),
        .i_transparent  (r_transparent),
        .i_replacement  (r_replacement),
        .o_valid        (req_valid),
        .o_req          (req)
    );

    pcpd_addr #(
        .SIDE_W (SIDE_W)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (req_valid),
        .i_req       (req),
        .i_width     (width_c),
        .i_out_ready (m_axis_tready),
        .o_advance   (out_ready_path),
        .o_valid     (m_axis_tvalid),
        .o_kind      (out_kind),
        .o_addr      (out_addr),
        .o_value     (out_value)
    );

    assign m_axis_tdata = {out_value, out_addr};
    assign m_axis_tuser = out_kind;

endmodule
